// ===== rtl/pnm_header_parser_core_defines.svh =====
// Assertion helpers for the PNM header parser.
// Each macro expands to one labelled concurrent assertion on i_clk,
// disabled while i_rst_n is low.
`ifndef PNM_HEADER_PARSER_CORE_DEFINES_SVH
`define PNM_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define PNM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pnm_hp_pkg.sv =====
`timescale 1ns / 1ps
package pnm_hp_pkg;

    localparam int VALUE_BITS = 16;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_HASH = 8'd35;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_ONE  = 8'd49;
    localparam logic [7:0] CH_SIX  = 8'd54;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_P    = 8'd80;

    // image type codes; bitmap types report a maximum sample of one
    localparam logic [2:0] TYPE_NONE      = 3'd0;
    localparam logic [2:0] TYPE_PBM_ASCII = 3'd1;
    localparam logic [2:0] TYPE_PBM_RAW   = 3'd4;

    typedef enum logic [3:0] {
        ST_OK,
        ST_NOT_P,
        ST_MAGIC_LEN,
        ST_TYPE_RANGE,
        ST_SIZE_CHAR,
        ST_SPACING,
        ST_WIDTH_ZERO,
        ST_HEIGHT_ZERO,
        ST_MAX_ZERO,
        ST_MAX_CHAR,
        ST_TOO_LARGE
    } t_status;

    // one classified header byte
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       is_nl;
        logic       is_sp;
        logic       is_digit;
        logic       is_zero;
        logic       is_p;
        logic       is_hash;
        logic [3:0] digit;
    } t_sym;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  ovf;
    } t_acc;

    // acc * 10 + digit with shifts and adds, held at the all-ones limit
    function automatic t_acc acc_step(input logic [VALUE_BITS-1:0] acc,
                                      input logic [3:0] digit);
        logic [VALUE_BITS+3:0] wide;
        logic [VALUE_BITS+3:0] sum;
        t_acc                  res;
        wide = {4'b0, acc};
        sum  = (wide << 3) + (wide << 1) + {{VALUE_BITS{1'b0}}, digit};
        if (sum[VALUE_BITS+3:VALUE_BITS] != 4'b0) begin
            res.value = {VALUE_BITS{1'b1}};
            res.ovf   = 1'b1;
        end else begin
            res.value = sum[VALUE_BITS-1:0];
            res.ovf   = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== rtl/pnm_header_parser_core.sv =====
`timescale 1ns / 1ps
// PNM header parser: one header byte per cycle while o_stall is low, one result per header.
// A header's final byte is written into the byte queue, then popped by the back end, which registers the result.
// Throughput: one byte per cycle while o_stall is low; the back end parses each popped byte combinationally.
// The four-entry byte queue keeps taking bytes until full while a result waits on o_valid.
// Reset: i_rst_n synchronous, active low; clears queue, parser state and o_valid.
module pnm_header_parser_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_start_of_file,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_status,
    output logic [2:0]                        o_image_type,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_width,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_height,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_max_sample
);
    import pnm_hp_pkg::*;

    // front to back queue interface
    logic q_valid;
    t_sym q_sym;
    logic q_pop;

    // Front end: classifies each byte (newline, space, digit, 'P', '#')
    // and parks the request in a small queue. o_stall only rises when the
    // queue is full, i.e. when the back end has been held by i_stall.
    pnm_hp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_q_valid       (q_valid),
        .o_q_sym         (q_sym),
        .i_q_pop         (q_pop)
    );

    // Back end: header state machine. Pops one byte per cycle as long as
    // the result register is free or being drained. Decimal fields are
    // built with x10 via shift-and-add and clamp at the all-ones value.
    // After the result, bytes are swallowed until start_of_file.
    pnm_hp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_sym        (q_sym),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_image_type   (o_image_type),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_max_sample   (o_max_sample)
    );

endmodule

// ===== rtl/pnm_hp_front.sv =====
`timescale 1ns / 1ps
module pnm_hp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_file,
    output logic              o_q_valid,
    output pnm_hp_pkg::t_sym  o_q_sym,
    input  logic              i_q_pop
);
    import pnm_hp_pkg::*;

    t_sym            w_sym;
    t_sym            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_count, n_count;
    logic            w_push;
    logic            w_pop;

    // byte classification
    always_comb begin
        w_sym.data     = i_data_byte;
        w_sym.sof      = i_start_of_file;
        w_sym.is_nl    = (i_data_byte == CH_NL);
        w_sym.is_sp    = (i_data_byte == CH_SP);
        w_sym.is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
        w_sym.is_zero  = (i_data_byte == CH_ZERO);
        w_sym.is_p     = (i_data_byte == CH_P);
        w_sym.is_hash  = (i_data_byte == CH_HASH);
        w_sym.digit    = 4'(i_data_byte - CH_ZERO);
    end

    assign o_stall   = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_sym   = r_mem[r_rd_ptr];
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_sym;
        end
    end

endmodule

// ===== rtl/pnm_hp_back.sv =====
`timescale 1ns / 1ps
module pnm_hp_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  pnm_hp_pkg::t_sym                  i_q_sym,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_status,
    output logic [2:0]                        o_image_type,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_width,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_height,
    output logic [pnm_hp_pkg::VALUE_BITS-1:0] o_max_sample
);
    import pnm_hp_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_LINE2,
        PH_COMMENT,
        PH_SIZE,
        PH_MAX,
        PH_DONE
    } t_phase;

    t_phase                r_phase, c_phase, n_phase;
    logic [1:0]            r_len, c_len, n_len;
    logic [7:0]            r_first, c_first, n_first;
    logic [7:0]            r_second, c_second, n_second;
    logic [1:0]            r_spaces, c_spaces, n_spaces;
    logic                  r_hlz, c_hlz, n_hlz;
    logic [2:0]            r_type, c_type, n_type;
    logic [VALUE_BITS-1:0] r_width, c_width, n_width;
    logic [VALUE_BITS-1:0] r_height, c_height, n_height;
    logic [VALUE_BITS-1:0] r_max, c_max, n_max;
    logic                  r_ovf, c_ovf, n_ovf;

    logic                  r_out_valid;
    t_status               r_status;
    logic [2:0]            r_type_out;
    logic [VALUE_BITS-1:0] r_width_out, r_height_out, r_max_out;

    logic                  w_pop;
    logic                  w_emit;
    logic                  w_vals;
    logic                  w_size;
    t_status               w_status;
    logic                  w_one_max;
    t_sym                  s;
    t_acc                  w_acc_w, w_acc_h, w_acc_m;

    assign w_pop   = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop = w_pop;
    assign s       = i_q_sym;

    assign w_acc_w = acc_step(c_width, s.digit);
    assign w_acc_h = acc_step(c_height, s.digit);
    assign w_acc_m = acc_step(c_max, s.digit);
    assign w_one_max = (c_type == TYPE_PBM_ASCII) || (c_type == TYPE_PBM_RAW);

    // start of file restarts from the reset state
    always_comb begin
        if (s.sof) begin
            c_phase  = PH_MAGIC;
            c_len    = '0;
            c_first  = '0;
            c_second = '0;
            c_spaces = '0;
            c_hlz    = 1'b0;
            c_type   = '0;
            c_width  = '0;
            c_height = '0;
            c_max    = '0;
            c_ovf    = 1'b0;
        end else begin
            c_phase  = r_phase;
            c_len    = r_len;
            c_first  = r_first;
            c_second = r_second;
            c_spaces = r_spaces;
            c_hlz    = r_hlz;
            c_type   = r_type;
            c_width  = r_width;
            c_height = r_height;
            c_max    = r_max;
            c_ovf    = r_ovf;
        end
    end

    always_comb begin
        n_phase  = c_phase;
        n_len    = c_len;
        n_first  = c_first;
        n_second = c_second;
        n_spaces = c_spaces;
        n_hlz    = c_hlz;
        n_type   = c_type;
        n_width  = c_width;
        n_height = c_height;
        n_max    = c_max;
        n_ovf    = c_ovf;
        w_emit   = 1'b0;
        w_vals   = 1'b0;
        w_size   = 1'b0;
        w_status = ST_OK;

        unique case (c_phase)
            PH_MAGIC: begin
                if (c_len == 2'd0) begin
                    if (!s.is_p) begin
                        w_emit = 1'b1; w_status = ST_NOT_P;
                    end else begin
                        n_first = s.data;
                        n_len   = 2'd1;
                    end
                end else if (c_len == 2'd1) begin
                    if (s.is_nl) begin
                        w_emit = 1'b1; w_status = ST_MAGIC_LEN;
                    end else begin
                        n_second = s.data;
                        n_len    = 2'd2;
                    end
                end else begin
                    if (!s.is_nl) begin
                        w_emit = 1'b1; w_status = ST_MAGIC_LEN;
                    end else if (c_second < CH_ONE || c_second > CH_SIX) begin
                        w_emit = 1'b1; w_status = ST_TYPE_RANGE;
                    end else begin
                        n_type   = 3'(c_second - CH_ZERO);
                        n_first  = '0;
                        n_second = '0;
                        n_len    = '0;
                        n_phase  = PH_LINE2;
                    end
                end
            end
            PH_LINE2: begin
                if (s.is_hash) begin
                    n_phase = PH_COMMENT;
                end else begin
                    n_phase = PH_SIZE;
                    w_size  = 1'b1;
                end
            end
            PH_COMMENT: begin
                if (s.is_nl) begin
                    n_phase = PH_SIZE;
                end
            end
            PH_SIZE: begin
                w_size = 1'b1;
            end
            PH_MAX: begin
                if (s.is_nl) begin
                    w_emit = 1'b1;
                    if (c_len == 2'd0) begin
                        w_status = ST_MAX_CHAR;
                    end else begin
                        w_status = c_ovf ? ST_TOO_LARGE : ST_OK;
                        w_vals   = 1'b1;
                    end
                end else if (c_len == 2'd0 && s.is_zero) begin
                    w_emit = 1'b1; w_status = ST_MAX_ZERO;
                end else if (!s.is_digit) begin
                    w_emit = 1'b1; w_status = ST_MAX_CHAR;
                end else begin
                    n_len = 2'd1;
                    if (!w_one_max) begin
                        n_max = w_acc_m.value;
                        n_ovf = c_ovf | w_acc_m.ovf;
                    end
                end
            end
            default: begin
            end
        endcase

        // width/height line
        if (w_size) begin
            if (s.is_nl) begin
                if (c_spaces != 2'd1 || c_first == CH_SP || c_second == 8'd0) begin
                    w_emit = 1'b1; w_status = ST_SPACING;
                end else if (c_first == CH_ZERO) begin
                    w_emit = 1'b1; w_status = ST_WIDTH_ZERO;
                end else if (c_hlz) begin
                    w_emit = 1'b1; w_status = ST_HEIGHT_ZERO;
                end else begin
                    n_phase = PH_MAX;
                    n_len   = '0;
                end
            end else if (!s.is_sp && !s.is_digit) begin
                w_emit = 1'b1; w_status = ST_SIZE_CHAR;
            end else begin
                if (c_len == 2'd0) begin
                    n_first = s.data;
                    n_len   = 2'd1;
                end
                if (c_spaces == 2'd1 && c_second == 8'd0) begin
                    n_second = s.data;
                    n_hlz    = s.is_zero;
                end
                if (s.is_sp) begin
                    if (c_spaces < 2'd2) begin
                        n_spaces = c_spaces + 2'd1;
                    end
                end else if (c_spaces == 2'd0) begin
                    n_width = w_acc_w.value;
                    n_ovf   = c_ovf | w_acc_w.ovf;
                end else if (c_spaces == 2'd1) begin
                    n_height = w_acc_h.value;
                    n_ovf    = c_ovf | w_acc_h.ovf;
                end
            end
        end

        if (w_emit) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_len        <= '0;
            r_first      <= '0;
            r_second     <= '0;
            r_spaces     <= '0;
            r_hlz        <= 1'b0;
            r_type       <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_max        <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_status     <= ST_OK;
            r_type_out   <= TYPE_NONE;
            r_width_out  <= '0;
            r_height_out <= '0;
            r_max_out    <= '0;
        end else begin
            if (w_pop) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_first  <= n_first;
                r_second <= n_second;
                r_spaces <= n_spaces;
                r_hlz    <= n_hlz;
                r_type   <= n_type;
                r_width  <= n_width;
                r_height <= n_height;
                r_max    <= n_max;
                r_ovf    <= n_ovf;
            end
            if (w_pop && w_emit) begin
                r_out_valid  <= 1'b1;
                r_status     <= w_status;
                r_type_out   <= c_type;
                r_width_out  <= w_vals ? c_width : '0;
                r_height_out <= w_vals ? c_height : '0;
                if (!w_vals) begin
                    r_max_out <= '0;
                end else if (w_one_max) begin
                    r_max_out <= VALUE_BITS'(1);
                end else begin
                    r_max_out <= c_max;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_image_type   = r_type_out;
    assign o_image_width  = r_width_out;
    assign o_image_height = r_height_out;
    assign o_max_sample   = r_max_out;

endmodule

// ===== rtl/pnm_hp_checker.sv =====
`timescale 1ns / 1ps
`include "pnm_header_parser_core_defines.svh"
module pnm_hp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [7:0]                        i_data_byte,
    input logic                              i_start_of_file,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [3:0]                        o_status,
    input logic [2:0]                        o_image_type,
    input logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_width,
    input logic [pnm_hp_pkg::VALUE_BITS-1:0] o_image_height,
    input logic [pnm_hp_pkg::VALUE_BITS-1:0] o_max_sample
);
    import pnm_hp_pkg::*;

    logic                      w_good;
    logic                      w_early;
    logic                      w_bitmap;
    logic                      w_no_sizes;
    logic                      w_max_one;
    logic [8:0]                w_req;
    logic [3*VALUE_BITS+6:0]   w_res;
    assign w_good  = (o_status == ST_OK) || (o_status == ST_TOO_LARGE);
    assign w_early = (o_status == ST_NOT_P) || (o_status == ST_MAGIC_LEN)
                  || (o_status == ST_TYPE_RANGE);
    assign w_bitmap   = (o_image_type == TYPE_PBM_ASCII) || (o_image_type == TYPE_PBM_RAW);
    assign w_no_sizes = (o_image_width == '0) && (o_image_height == '0)
                     && (o_max_sample == '0);
    assign w_max_one  = (o_max_sample == VALUE_BITS'(1));
    assign w_req      = {i_data_byte, i_start_of_file};
    assign w_res      = {o_status, o_image_type, o_image_width, o_image_height, o_max_sample};

    // stalled request holds its payload
    `PNM_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(w_req), "request moved")

    // held result stays put
    `PNM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_res), "result moved")

    // error results carry no sizes
    `PNM_ASSERT_NOW(a_err_zero, o_valid && !w_good, w_no_sizes, "error result with sizes")

    // magic-line errors happen before the type is known
    `PNM_ASSERT_NOW(a_early_type, o_valid && w_early, o_image_type == TYPE_NONE, "type set early")

    // bitmap types report a maximum of one
    `PNM_ASSERT_NOW(a_bitmap_max, o_valid && w_good && w_bitmap, w_max_one, "bitmap max not one")

endmodule

bind pnm_header_parser_core pnm_hp_checker u_pnm_hp_checker (.*);
